[design/mavp_pkg.sv]
// Shared constants and types for the multi-axis velocity PID core.
package mavp_pkg;

    // Loop geometry: two banks (down and up motion), AXES axes in each.
    localparam int AXES        = 8;
    localparam int BANKS       = 2;
    localparam int STATE_DEPTH = BANKS * AXES;
    localparam int IDX_W       = $clog2(STATE_DEPTH);

    // Field widths.
    localparam int AXIS_W   = 3;
    localparam int VEL_W    = 16;
    localparam int GAIN_W   = 16;
    localparam int LIMIT_W  = 15;
    localparam int FRAC_W   = 8;
    localparam int ERR_W    = VEL_W + 1;
    localparam int DERR_W   = ERR_W + 1;
    localparam int INTEG_W  = 24;

    // Intermediate widths of the datapath.
    localparam int PROD_W   = GAIN_W + 1 + ERR_W;
    localparam int DPROD_W  = GAIN_W + 1 + DERR_W;
    localparam int IRAW_W   = PROD_W + 1;
    localparam int SUM_W    = DPROD_W + 1;
    localparam int SHIFT_W  = SUM_W - FRAC_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP             = 3'd0,
        REG_KI             = 3'd1,
        REG_KD             = 3'd2,
        REG_INTEGRAL_LIMIT = 3'd3,
        REG_OUTPUT_LIMIT   = 3'd4
    } cfg_reg_t;

    // Register values after reset.
    localparam logic [GAIN_W-1:0]  KP_RESET             = '0;
    localparam logic [GAIN_W-1:0]  KI_RESET             = '0;
    localparam logic [GAIN_W-1:0]  KD_RESET             = '0;
    localparam logic [LIMIT_W-1:0] INTEGRAL_LIMIT_RESET = 15'd5000;
    localparam logic [LIMIT_W-1:0] OUTPUT_LIMIT_RESET   = 15'd12500;

endpackage

[design/multi_axis_velocity_pid_core.sv]
// Multi-axis velocity PID core: one registered pass per beat, per-loop state in flip-flops.
// Each accepted input beat passes the input register and then the output register.
// Throughput: one beat per cycle unless the output stalls; the input register feeds a single
// pass of three parallel gain multipliers, the integral clamp and the output saturation.
// Loop state written by one beat is seen by the beat right behind it.
// Reset clears all loop state, the gains, and restores the limits to 5000 and 12500.
module multi_axis_velocity_pid_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mavp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mavp_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Input channel.
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              bank,
    input  logic [mavp_pkg::AXIS_W-1:0]       axis,
    input  logic signed [mavp_pkg::VEL_W-1:0] measured_velocity,
    input  logic signed [mavp_pkg::VEL_W-1:0] setpoint_velocity,
    // Output channel.
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [mavp_pkg::VEL_W-1:0] drive
);
    import mavp_pkg::*;

    // Configuration registers.
    logic [GAIN_W-1:0]  kp_reg;
    logic [GAIN_W-1:0]  ki_reg;
    logic [GAIN_W-1:0]  kd_reg;
    logic [LIMIT_W-1:0] ilim_reg;
    logic [LIMIT_W-1:0] olim_reg;

    // Input stage.
    logic                     s1_valid_reg;
    logic                     s1_bank_reg;
    logic [AXIS_W-1:0]        s1_axis_reg;
    logic signed [VEL_W-1:0]  s1_meas_reg;
    logic signed [VEL_W-1:0]  s1_tgt_reg;

    // Output stage.
    logic                     out_valid_reg;
    logic signed [VEL_W-1:0]  drive_reg;
    logic signed [VEL_W-1:0]  drive_next;

    // Loop state, one entry per bank and axis.
    logic signed [ERR_W-1:0]   prev_err_reg [STATE_DEPTH];
    logic signed [INTEG_W-1:0] integ_reg    [STATE_DEPTH];

    // Datapath.
    logic                      advance;
    logic                      axis_ok;
    logic [IDX_W-1:0]          idx;
    logic signed [ERR_W-1:0]   err;
    logic signed [ERR_W-1:0]   prev_err;
    logic signed [INTEG_W-1:0] integ_old;
    logic signed [DERR_W-1:0]  derr;
    logic signed [ERR_W-1:0]   kp_s;
    logic signed [ERR_W-1:0]   ki_s;
    logic signed [ERR_W-1:0]   kd_s;
    logic signed [PROD_W-1:0]  kp_prod;
    logic signed [PROD_W-1:0]  ki_prod;
    logic signed [DPROD_W-1:0] kd_prod;
    logic signed [IRAW_W-1:0]  integ_raw;
    logic signed [IRAW_W-1:0]  ilim_q8;
    logic signed [INTEG_W-1:0] integ_next;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SHIFT_W-1:0] sum_int;
    logic signed [SHIFT_W-1:0] olim_s;

    // Handshake: the input stage moves on whenever the output register is free
    // or is being emptied in this cycle.
    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg   <= KP_RESET;
            ki_reg   <= KI_RESET;
            kd_reg   <= KD_RESET;
            ilim_reg <= INTEGRAL_LIMIT_RESET;
            olim_reg <= OUTPUT_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_KP:             kp_reg   <= cfg_data;
                REG_KI:             ki_reg   <= cfg_data;
                REG_KD:             kd_reg   <= cfg_data;
                REG_INTEGRAL_LIMIT: ilim_reg <= cfg_data[LIMIT_W-1:0];
                REG_OUTPUT_LIMIT:   olim_reg <= cfg_data[LIMIT_W-1:0];
                default:            ;
            endcase
        end
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_bank_reg <= bank;
            s1_axis_reg <= axis;
            s1_meas_reg <= measured_velocity;
            s1_tgt_reg  <= setpoint_velocity;
        end
    end

    // Loop state lookup.
    assign axis_ok   = (32'(s1_axis_reg) < AXES);
    assign idx       = IDX_W'(s1_axis_reg) + (s1_bank_reg ? IDX_W'(AXES) : IDX_W'(0));
    assign prev_err  = prev_err_reg[idx];
    assign integ_old = integ_reg[idx];

    // Error terms and the three gain products, all exact.
    assign err     = ERR_W'(s1_tgt_reg) - ERR_W'(s1_meas_reg);
    assign derr    = DERR_W'(err) - DERR_W'(prev_err);
    assign kp_s    = $signed({1'b0, kp_reg});
    assign ki_s    = $signed({1'b0, ki_reg});
    assign kd_s    = $signed({1'b0, kd_reg});
    assign kp_prod = PROD_W'(kp_s) * PROD_W'(err);
    assign ki_prod = PROD_W'(ki_s) * PROD_W'(err);
    assign kd_prod = DPROD_W'(kd_s) * DPROD_W'(derr);

    // Integral accumulate and symmetric clamp to the Q.8 limit.
    assign integ_raw = IRAW_W'(integ_old) + IRAW_W'(ki_prod);
    assign ilim_q8   = IRAW_W'($signed({1'b0, ilim_reg, {FRAC_W{1'b0}}}));

    always_comb
    begin
        if (integ_raw > ilim_q8)
        begin
            integ_next = INTEG_W'(ilim_q8);
        end
        else if (integ_raw < -ilim_q8)
        begin
            integ_next = INTEG_W'(-ilim_q8);
        end
        else
        begin
            integ_next = INTEG_W'(integ_raw);
        end
    end

    // PID sum, floor to integer by arithmetic shift, then output saturation.
    assign sum     = SUM_W'(kp_prod) + SUM_W'(kd_prod) + SUM_W'(integ_next);
    assign sum_int = $signed(sum[SUM_W-1:FRAC_W]);
    assign olim_s  = SHIFT_W'($signed({1'b0, olim_reg}));

    always_comb
    begin
        if (!axis_ok)
        begin
            drive_next = '0;
        end
        else if (sum_int > olim_s)
        begin
            drive_next = VEL_W'(olim_s);
        end
        else if (sum_int < -olim_s)
        begin
            drive_next = VEL_W'(-olim_s);
        end
        else
        begin
            drive_next = VEL_W'(sum_int);
        end
    end

    // Loop state update as the beat leaves the input stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STATE_DEPTH; i++)
            begin
                prev_err_reg[i] <= '0;
                integ_reg[i]    <= '0;
            end
        end
        else if (s1_valid_reg && advance && axis_ok)
        begin
            prev_err_reg[idx] <= err;
            integ_reg[idx]    <= integ_next;
        end
    end

    // Output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            drive_reg <= drive_next;
        end
    end

endmodule

[bench/multi_axis_velocity_pid_core_tb.sv]
// Testbench for the multi-axis velocity PID core: random and directed beats checked against a PID predictor.
`timescale 1ns / 100ps

module multi_axis_velocity_pid_core_tb;
    import mavp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PHASES = 10;
    localparam int BEATS_PER_PHASE = 155;

    typedef struct packed {
        logic                    bank;
        logic [AXIS_W-1:0]       axis;
        logic signed [VEL_W-1:0] measured;
        logic signed [VEL_W-1:0] target;
    } vel_sample_t;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } rx_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic bank = 1'b0;
    logic [AXIS_W-1:0] axis = '0;
    logic signed [VEL_W-1:0] measured_velocity = '0;
    logic signed [VEL_W-1:0] setpoint_velocity = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [VEL_W-1:0] drive;

    // Mirror of the gain and limit registers.
    logic [GAIN_W-1:0] kp_gain = KP_RESET;
    logic [GAIN_W-1:0] ki_gain = KI_RESET;
    logic [GAIN_W-1:0] kd_gain = KD_RESET;
    logic [LIMIT_W-1:0] integ_limit = INTEGRAL_LIMIT_RESET;
    logic [LIMIT_W-1:0] out_limit = OUTPUT_LIMIT_RESET;

    // Mirror of the per-loop state, cleared at reset.
    logic signed [ERR_W-1:0] prev_err [STATE_DEPTH];
    logic signed [INTEG_W-1:0] integ_q8 [STATE_DEPTH];

    vel_sample_t pending_samples[$];
    logic signed [VEL_W-1:0] expected_drive[$];
    int mismatch_count = 0;
    int cycle_count = 0;
    logic in_beat_taken = 1'b0;
    int gap_left = 0;
    int burst_left = 0;
    rx_mode_t rx_mode = RX_FREE;
    int rx_count = 0;

    multi_axis_velocity_pid_core u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .bank              (bank),
        .axis              (axis),
        .measured_velocity (measured_velocity),
        .setpoint_velocity (setpoint_velocity),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .drive             (drive)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint clamp_sym(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // One PID step on the addressed loop; updates the mirrored state.
    function automatic logic signed [VEL_W-1:0] next_drive(vel_sample_t s);
        int slot;
        longint err;
        longint acc;
        longint sum;
        longint q;
        if (int'(s.axis) >= AXES)
            return '0;
        slot = int'(s.bank) * AXES + int'(s.axis);
        err = longint'($signed(s.target)) - longint'($signed(s.measured));
        acc = longint'(integ_q8[slot]) + longint'(ki_gain) * err;
        acc = clamp_sym(acc, longint'(integ_limit) * 256);
        sum = longint'(kp_gain) * err
            + longint'(kd_gain) * (err - longint'(prev_err[slot]))
            + acc;
        // Arithmetic shift floors the Q.8 sum to an integer.
        q = clamp_sym(sum >>> FRAC_W, longint'(out_limit));
        integ_q8[slot] = acc[INTEG_W-1:0];
        prev_err[slot] = err[ERR_W-1:0];
        return q[VEL_W-1:0];
    endfunction

    // Input driver: bursts of beats with random gaps, changes at the falling edge.
    always @(negedge clk)
    begin
        vel_sample_t cur;
        if (rst_n && (!in_valid || in_beat_taken))
        begin
            if (gap_left != 0)
            begin
                gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_samples.size() != 0)
            begin
                cur = pending_samples.pop_front();
                in_valid <= 1'b1;
                bank <= cur.bank;
                axis <= cur.axis;
                measured_velocity <= cur.measured;
                setpoint_velocity <= cur.target;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left = burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Output stall pattern, in one of four modes chosen at random.
    always @(negedge clk)
    begin
        rx_count = rx_count + 1;
        if (rx_count % 48 == 0)
            rx_mode = rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_FREE:   out_ready <= 1'b1;
            RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: out_ready <= (rx_count % 4 == 0);
            default:   out_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Monitor: check output beats first, then predict for the accepted input beat.
    always @(posedge clk)
    begin
        vel_sample_t seen;
        logic signed [VEL_W-1:0] want;
        in_beat_taken = rst_n && in_valid && in_ready;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_drive.size() == 0)
            begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= 10)
                    $display("unexpected drive beat: actual %0d", drive);
            end
            else
            begin
                want = expected_drive.pop_front();
                if (drive !== want)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("drive mismatch: expected %0d actual %0d", want, drive);
                end
            end
        end
        if (in_beat_taken)
        begin
            seen = {bank, axis, measured_velocity, setpoint_velocity};
            expected_drive.push_back(next_drive(seen));
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("multi_axis_velocity_pid_core_tb: FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_KP:             kp_gain = data;
            REG_KI:             ki_gain = data;
            REG_KD:             kd_gain = data;
            REG_INTEGRAL_LIMIT: integ_limit = data[LIMIT_W-1:0];
            REG_OUTPUT_LIMIT:   out_limit = data[LIMIT_W-1:0];
            default:            ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [15:0] p, input logic [15:0] i, input logic [15:0] d,
                             input logic [15:0] il, input logic [15:0] ol);
        write_reg(REG_KP, p);
        write_reg(REG_KI, i);
        write_reg(REG_KD, d);
        write_reg(REG_INTEGRAL_LIMIT, il);
        write_reg(REG_OUTPUT_LIMIT, ol);
    endtask

    task automatic queue_sample(input logic b, input int ax, input int meas, input int targ);
        vel_sample_t s;
        s.bank = b;
        s.axis = ax[AXIS_W-1:0];
        s.measured = meas[VEL_W-1:0];
        s.target = targ[VEL_W-1:0];
        pending_samples.push_back(s);
    endtask

    // Wait until every queued beat has gone in and every drive beat has come back.
    task automatic wait_drained();
        while (pending_samples.size() != 0 || in_valid || expected_drive.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 4))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 1023));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Limits carry a random top data bit, which the register drops.
    function automatic logic [15:0] pick_limit();
        logic [14:0] lim;
        case ($urandom_range(0, 4))
            0:       lim = 15'd0;
            1:       lim = 15'h7FFF;
            2:       lim = 15'($urandom_range(0, 300));
            default: lim = 15'($urandom_range(0, 32767));
        endcase
        return {1'($urandom_range(0, 1)), lim};
    endfunction

    function automatic int pick_vel();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 600) - 300;
            1:       return -32768;
            2:       return 32767;
            3:       return $urandom_range(0, 1) - 1;
            default: return $urandom_range(0, 65535) - 32768;
        endcase
    endfunction

    task automatic queue_random(input int count, input bit narrow);
        int meas;
        int targ;
        for (int n = 0; n < count; n++)
        begin
            meas = pick_vel();
            if ($urandom_range(0, 1) == 0)
                targ = pick_vel();
            else
                targ = meas + $urandom_range(0, 200) - 100;
            queue_sample(1'($urandom_range(0, 1)),
                         narrow ? $urandom_range(0, 1) : $urandom_range(0, 7), meas, targ);
        end
    endtask

    // Stimulus sequence.
    initial
    begin
        for (int k = 0; k < STATE_DEPTH; k++)
        begin
            prev_err[k] = '0;
            integ_q8[k] = '0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: all gains zero, so the drive stays at zero.
        queue_sample(1'b0, 0, -32768, 32767);
        queue_sample(1'b1, 7, 32767, -32768);
        wait_drained();

        // Pure proportional at unity gain: output saturation boundary.
        write_all(16'd256, 16'd0, 16'd0, 16'd5000, 16'd12500);
        queue_sample(1'b0, 1, 0, 12500);
        queue_sample(1'b0, 2, 0, 12501);
        queue_sample(1'b0, 3, 0, -12500);
        queue_sample(1'b1, 4, 0, -12501);
        queue_sample(1'b1, 5, -32768, 32767);
        queue_sample(1'b1, 6, 100, 99);
        wait_drained();

        // Integral clamp on one loop, with flooring of negative sums.
        write_all(16'd128, 16'd256, 16'd0, 16'd100, 16'd32767);
        queue_sample(1'b0, 0, 0, 1);
        queue_sample(1'b0, 0, 0, -3);
        queue_sample(1'b0, 0, 0, 60);
        queue_sample(1'b0, 0, 0, 60);
        queue_sample(1'b0, 0, 0, 60);
        queue_sample(1'b0, 0, 60, 0);
        wait_drained();

        // Maximum gains and limits with a full derivative swing.
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF);
        queue_sample(1'b1, 0, -32768, 32767);
        queue_sample(1'b1, 0, 32767, -32768);
        queue_sample(1'b0, 7, -1, 0);
        wait_drained();

        // Zero limits force both the integral and the drive to zero.
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
        queue_sample(1'b0, 4, 123, -456);
        queue_sample(1'b1, 3, -32768, 32767);
        wait_drained();

        // Random phases, each with fresh settings.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            write_all(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit());
            if (ph == 0)
                write_reg(CFG_IDX_W'(REG_OUTPUT_LIMIT + 1 + $urandom_range(0, 2)),
                          16'($urandom_range(0, 65535)));
            if (ph == 3)
            begin
                // Let the pipe empty completely in the middle of a phase.
                queue_random(BEATS_PER_PHASE / 2, 1'b0);
                wait_drained();
                queue_random(BEATS_PER_PHASE - BEATS_PER_PHASE / 2, 1'b0);
            end
            else
                queue_random(BEATS_PER_PHASE, 1'($urandom_range(0, 1)));
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && expected_drive.size() == 0)
            $display("multi_axis_velocity_pid_core_tb: PASS");
        else
            $display("multi_axis_velocity_pid_core_tb: FAIL");
        $finish;
    end

endmodule

[multi_axis_velocity_pid_core.f]
design/mavp_pkg.sv
design/multi_axis_velocity_pid_core.sv
bench/multi_axis_velocity_pid_core_tb.sv
